>>> design/signed_muldiv_floor_ceil_macros.svh
// Assertion macros for the signed multiply-divide block.
// Used by the top level only; no other dependencies.
`ifndef SIGNED_MULDIV_FLOOR_CEIL_MACROS_SVH
`define SIGNED_MULDIV_FLOOR_CEIL_MACROS_SVH
`ifndef SYNTHESIS
`define SMFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMFC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SMFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/smfc_pkg.sv
// Shared types and constants for the signed multiply-divide block.
// No dependencies.
package smfc_pkg;

    localparam int WORK_W    = 63;          // magnitude of the product, at most 2^62
    localparam int DEN_W     = 31;
    localparam int NUM_CELLS = WORK_W;      // one quotient bit per cell

    localparam logic [31:0] QUOT_HIGH_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] QUOT_LOW_LIMIT  = 32'h8000_0000;

    typedef enum logic [1:0] {
        OVF_NONE = 2'd0,
        OVF_HIGH = 2'd1,
        OVF_LOW  = 2'd2
    } t_ovf_code;

    typedef struct packed {
        logic               action;
        logic signed [31:0] first_factor;
        logic signed [31:0] second_factor;
        logic [DEN_W-1:0]   denominator;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] quotient;
        logic [DEN_W-1:0]   floor_remainder;
        logic [1:0]         overflow_code;
    } t_out_req;

    // Data handed from cell to cell along the divider chain.
    typedef struct packed {
        logic              neg;    // product was negative
        logic              ceil;   // ceiling rounding requested
        logic              dz;     // zero denominator
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;    // partial remainder
        logic [WORK_W-1:0] work;   // dividend bits left, quotient bits shifted in
    } t_div_lane;

endpackage

>>> design/signed_muldiv_floor_ceil.sv
// Signed multiply-divide with floor or ceiling rounding: the block takes one
// request per cycle while o_ready is high and returns results in order. A
// front end forms the signed 64-bit product and then its magnitude, a chain of
// 63 division cells resolves one quotient bit per cell, a back end applies
// floor/ceiling correction and then 32-bit saturation, and an output register
// with a skid entry holds the result. A stalled output halts the whole
// pipeline only once the skid entry is full.
// Depends on smfc_pkg and signed_muldiv_floor_ceil_macros.svh.
`include "signed_muldiv_floor_ceil_macros.svh"

module signed_muldiv_floor_ceil (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  smfc_pkg::t_in_req  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output smfc_pkg::t_out_req o_data
);
    import smfc_pkg::*;

    logic                 w_en;
    logic [NUM_CELLS:0]   w_cell_valid;
    t_div_lane            w_cell_lane [NUM_CELLS+1];
    logic                 w_fix_valid;
    t_out_req             w_fix_data;

    assign o_ready = w_en;

    smfc_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_cell_valid[0]),
        .o_lane  (w_cell_lane[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        smfc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cell_valid[g]),
            .i_lane  (w_cell_lane[g]),
            .o_valid (w_cell_valid[g+1]),
            .o_lane  (w_cell_lane[g+1])
        );
    end

    smfc_fix_stage u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cell_valid[NUM_CELLS]),
        .i_lane  (w_cell_lane[NUM_CELLS]),
        .o_valid (w_fix_valid),
        .o_data  (w_fix_data)
    );

    smfc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fix_valid && w_en),
        .i_data  (w_fix_data),
        .o_space (w_en),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    // a full skid entry implies a result is on the output
    `SMFC_ASSERT_IMPL(a_stall_has_output, i_clk, i_rst_n, !o_ready, o_valid,
        "pipeline stalled with no result on the output")
    `SMFC_ASSERT_IMPL(a_high_is_max, i_clk, i_rst_n,
        o_valid && (o_data.overflow_code == OVF_HIGH), o_data.quotient == QUOT_HIGH_LIMIT,
        "high saturation without the upper limit")
    `SMFC_ASSERT_IMPL(a_low_is_min, i_clk, i_rst_n,
        o_valid && (o_data.overflow_code == OVF_LOW), o_data.quotient == QUOT_LOW_LIMIT,
        "low saturation without the lower limit")
    `SMFC_ASSERT_NEXT(a_stall_no_request, i_clk, i_rst_n,
        o_valid && !i_ready && !o_ready, !o_ready,
        "skid entry lost while the output was stalled")

endmodule

>>> design/smfc_mul_stage.sv
// Front end: signed 32x32 product, then its magnitude, as two register stages.
// Depends on smfc_pkg.
module smfc_mul_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  smfc_pkg::t_in_req  i_data,
    output logic               o_valid,
    output smfc_pkg::t_div_lane o_lane
);
    import smfc_pkg::*;

    logic               r_v1;
    logic signed [63:0] r_prod;
    logic               r_ceil1;
    logic [DEN_W-1:0]   r_den1;
    logic signed [63:0] n_prod;

    logic               r_v2;
    t_div_lane          r_lane;
    logic [63:0]        n_mag;

    assign n_prod = $signed(i_data.first_factor) * $signed(i_data.second_factor);
    assign n_mag  = r_prod[63] ? (~r_prod + 64'd1) : r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod      <= n_prod;
            r_ceil1     <= i_data.action;
            r_den1      <= i_data.denominator;
            r_lane.neg  <= r_prod[63];
            r_lane.ceil <= r_ceil1;
            r_lane.dz   <= (r_den1 == '0);
            r_lane.den  <= r_den1;
            r_lane.rem  <= '0;
            r_lane.work <= n_mag[WORK_W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_lane  = r_lane;

endmodule

>>> design/smfc_div_cell.sv
// One restoring-division cell: shifts in a dividend bit, trial-subtracts the
// divisor and shifts in one quotient bit. Depends on smfc_pkg.
module smfc_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  smfc_pkg::t_div_lane i_lane,
    output logic                o_valid,
    output smfc_pkg::t_div_lane o_lane
);
    import smfc_pkg::*;

    logic             r_valid;
    t_div_lane        r_lane;
    t_div_lane        n_lane;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    always_comb begin
        w_trial = {i_lane.rem, i_lane.work[WORK_W-1]};
        w_ge    = (w_trial >= {1'b0, i_lane.den});
        w_diff  = w_trial - {1'b0, i_lane.den};
        n_lane      = i_lane;
        n_lane.rem  = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        n_lane.work = {i_lane.work[WORK_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

>>> design/smfc_fix_stage.sv
// Back end: floor correction of the sign, ceiling step and saturation,
// as two register stages. Depends on smfc_pkg.
module smfc_fix_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  smfc_pkg::t_div_lane i_lane,
    output logic                o_valid,
    output smfc_pkg::t_out_req  o_data
);
    import smfc_pkg::*;

    logic             r_va;
    logic [63:0]      r_qf;
    logic [DEN_W-1:0] r_rem;
    logic             r_ceil;
    logic             r_dz;
    logic             r_neg;

    logic [63:0]      n_qf;
    logic [DEN_W-1:0] n_rem;
    logic [63:0]      w_ext;
    logic             w_r0z;

    logic             r_vb;
    t_out_req         r_out;
    t_out_req         n_out;
    logic [63:0]      w_qc;
    logic             w_hi;
    logic             w_lo;

    // Stage A: turn the magnitude quotient into the floor quotient.
    always_comb begin
        w_ext = {1'b0, i_lane.work};
        w_r0z = (i_lane.rem == '0);
        if (!i_lane.neg) begin
            n_qf  = w_ext;
            n_rem = i_lane.rem;
        end else if (w_r0z) begin
            n_qf  = ~w_ext + 64'd1;
            n_rem = '0;
        end else begin
            n_qf  = ~w_ext;
            n_rem = i_lane.den - i_lane.rem;
        end
    end

    // Stage B: step up for ceiling, then clamp to 32 bits.
    always_comb begin
        w_qc = r_qf + {63'd0, (r_ceil && (r_rem != '0))};
        w_hi = !w_qc[63] && (w_qc[62:31] != '0);
        w_lo = w_qc[63] && !(&w_qc[62:31]);
        n_out.floor_remainder = r_rem;
        if (r_dz) begin
            n_out.floor_remainder = '0;
            n_out.quotient        = r_neg ? QUOT_LOW_LIMIT : QUOT_HIGH_LIMIT;
            n_out.overflow_code   = r_neg ? OVF_LOW : OVF_HIGH;
        end else if (w_hi) begin
            n_out.quotient      = QUOT_HIGH_LIMIT;
            n_out.overflow_code = OVF_HIGH;
        end else if (w_lo) begin
            n_out.quotient      = QUOT_LOW_LIMIT;
            n_out.overflow_code = OVF_LOW;
        end else begin
            n_out.quotient      = w_qc[31:0];
            n_out.overflow_code = OVF_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qf   <= n_qf;
            r_rem  <= n_rem;
            r_ceil <= i_lane.ceil;
            r_dz   <= i_lane.dz;
            r_neg  <= i_lane.neg;
            r_out  <= n_out;
        end
    end

    assign o_valid = r_vb;
    assign o_data  = r_out;

endmodule

>>> design/smfc_skid.sv
// Output register with one skid entry, so the pipeline keeps moving while a
// result waits. Depends on smfc_pkg.
module smfc_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  smfc_pkg::t_out_req i_data,
    output logic               o_space,
    output logic               o_valid,
    output smfc_pkg::t_out_req o_data,
    input  logic               i_ready
);
    import smfc_pkg::*;

    logic     r_out_valid;
    logic     r_skid_valid;
    t_out_req r_out;
    t_out_req r_skid;
    logic     n_out_valid;
    logic     n_skid_valid;
    t_out_req n_out;
    t_out_req n_skid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                // drain the skid entry first; no push can arrive while it is full
                n_out_valid  = 1'b1;
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_push;
                n_out       = i_data;
            end
        end else if (i_push) begin
            n_skid_valid = 1'b1;
            n_skid       = i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_space = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> tb/smfc_result_checker.sv
// Result checker for signed_muldiv_floor_ceil: predicts each accepted request
// and compares every returned result, in order. Depends on smfc_pkg.
module smfc_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  smfc_pkg::t_in_req  i_req,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  smfc_pkg::t_out_req i_res,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import smfc_pkg::*;

    localparam longint QUO_MAX = 64'sd2147483647;
    localparam longint QUO_MIN = -64'sd2147483648;

    t_out_req expected_results[$];

    // Floor quotient of the exact product, bumped for ceiling, then saturated.
    function automatic t_out_req muldiv_result(input t_in_req req);
        longint   product;
        longint   den;
        longint   quo;
        longint   rem;
        t_out_req res;
        product = longint'($signed(req.first_factor)) * longint'($signed(req.second_factor));
        den     = longint'({1'b0, req.denominator});
        res     = '0;
        if (den == 0) begin
            res.quotient      = (product >= 0) ? QUOT_HIGH_LIMIT : QUOT_LOW_LIMIT;
            res.overflow_code = (product >= 0) ? OVF_HIGH : OVF_LOW;
            return res;
        end
        quo = product / den;
        rem = product % den;
        // truncating division: pull negative remainders back into range
        if (rem < 0) begin
            quo = quo - 1;
            rem = rem + den;
        end
        if (req.action && rem != 0)
            quo = quo + 1;
        res.overflow_code = OVF_NONE;
        if (quo > QUO_MAX) begin
            quo               = QUO_MAX;
            res.overflow_code = OVF_HIGH;
        end else if (quo < QUO_MIN) begin
            quo               = QUO_MIN;
            res.overflow_code = OVF_LOW;
        end
        res.quotient        = quo[31:0];
        res.floor_remainder = rem[DEN_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_req want;
        if (!i_rst_n) begin
            expected_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_req_valid && i_req_ready)
                expected_results.push_back(muldiv_result(i_req));
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none, got q=%0d r=%0d ovf=%0d",
                             $time, i_res.quotient, i_res.floor_remainder,
                             i_res.overflow_code);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.quotient !== want.quotient) begin
                        $display("%0t quotient: expected %0d, got %0d",
                                 $time, want.quotient, i_res.quotient);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.floor_remainder !== want.floor_remainder) begin
                        $display("%0t floor_remainder: expected %0d, got %0d",
                                 $time, want.floor_remainder, i_res.floor_remainder);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_res.overflow_code !== want.overflow_code) begin
                        $display("%0t overflow_code: expected %0d, got %0d",
                                 $time, want.overflow_code, i_res.overflow_code);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

>>> tb/tb.sv
// Top of the signed multiply-divide testbench: clock, reset, request and
// result traffic with idling phases. Depends on smfc_pkg, the block and
// smfc_result_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smfc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int NUM_PHASES    = 5;
    localparam int PHASE_ITEMS   = 285;
    localparam int DRAIN_CYCLES  = 100;
    localparam int LONG_HOLD     = 400;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    t_in_req  req_data;
    logic     res_valid;
    logic     res_ready;
    t_out_req res_data;
    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_req = 0;
    int       hold_left = 0;
    int       hold_done = 0;

    // sender idle and receiver stall percentages per phase
    int phase_idle[NUM_PHASES]  = '{0, 76, 0, 16, 0};
    int phase_stall[NUM_PHASES] = '{0, 0, 76, 16, 0};

    signed_muldiv_floor_ceil i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_data  (req_data),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_data  (res_data)
    );

    smfc_result_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req_data),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold-off once it is requested.
    initial begin
        res_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                res_ready <= 1'b0;
            end else if (hold_req > 0 && hold_done == 0) begin
                hold_left = hold_req - 1;
                hold_done = 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic t_in_req make_req(input logic act, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] d);
        t_in_req req;
        req.action        = act;
        req.first_factor  = a;
        req.second_factor = b;
        req.denominator   = d[30:0];
        return req;
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic t_in_req random_req();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] d;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                a = $urandom;
                b = $urandom;
                d = $urandom;
            end
            4: begin
                a = int'($urandom_range(200)) - 100;
                b = int'($urandom_range(200)) - 100;
                d = $urandom_range(20, 1);
            end
            5: begin
                a = corner_word();
                b = corner_word();
                case ($urandom_range(3))
                    0: d = 0;
                    1: d = 1;
                    2: d = 2;
                    default: d = 32'h7FFF_FFFF;
                endcase
            end
            6: begin
                // first factor near the divisor, second factor near a saturation limit
                d = $urandom_range(32'h7FFF_FFFF, 1);
                a = d + int'($urandom_range(2)) - 1;
                b = ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                    + int'($urandom_range(4)) - 2;
            end
            default: begin
                a = $urandom >> $urandom_range(31);
                b = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    a = -a;
                if ($urandom_range(1))
                    b = -b;
                d = $urandom_range(32'h7FFF_FFFF) >> $urandom_range(31);
            end
        endcase
        return make_req($urandom_range(1) != 0, a, b, d);
    endfunction

    task automatic send_req(input t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        do @(posedge clk); while (!req_ready);
    endtask

    initial begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: exact, inexact, signs, limits, zero divisor
        send_req(make_req(1'b0, 0, 0, 1));
        send_req(make_req(1'b0, 7, 3, 2));
        send_req(make_req(1'b1, 7, 3, 2));
        send_req(make_req(1'b0, -7, 3, 2));
        send_req(make_req(1'b1, -7, 3, 2));
        send_req(make_req(1'b0, -6, 2, 3));
        send_req(make_req(1'b1, -6, 2, 3));
        send_req(make_req(1'b0, 32'h8000_0000, 32'h8000_0000, 1));
        send_req(make_req(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_req(make_req(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_req(make_req(1'b0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF));
        send_req(make_req(1'b0, -1, 1, 32'h7FFF_FFFF));
        send_req(make_req(1'b1, -1, 1, 32'h7FFF_FFFF));
        // ceiling pushes the top floor quotient over the limit
        send_req(make_req(1'b0, 65537, 65535, 2));
        send_req(make_req(1'b1, 65537, 65535, 2));
        // floor drops one below the bottom limit, ceiling stays in range
        send_req(make_req(1'b0, -641, 6700417, 2));
        send_req(make_req(1'b1, -641, 6700417, 2));
        send_req(make_req(1'b0, 5, 3, 0));
        send_req(make_req(1'b1, -5, 3, 0));
        send_req(make_req(1'b0, 0, -9, 0));
        send_req(make_req(1'b0, 32'h8000_0000, 1, 1));
        send_req(make_req(1'b1, 32'h8000_0000, -1, 1));
        send_req(make_req(1'b1, 1, 1, 1));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            send_idle_pct = phase_idle[phase];
            stall_pct     = phase_stall[phase];
            // last phase: hold the result side off until the input backs up
            if (phase == NUM_PHASES - 1)
                hold_req = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_req(random_req());
        end
        req_valid <= 1'b0;
        stall_pct = 0;

        while (pending != 0 || hold_left > 0 || (hold_req > 0 && hold_done == 0))
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
